// ===== rtl/core/ckf_pkg.sv =====
// Shared types and constants for the CRC-16/Modbus packet framer.
// Holds byte kind codes, register indexes, the queue entry type and the CRC byte update.
// No dependencies.
package ckf_pkg;

  localparam int BYTE_W  = 8;
  localparam int ID_W    = 16;
  localparam int KIND_W  = 3;
  localparam int CRC_W   = 16;
  localparam int CFG_IDX_W = 8;

  // Byte kinds; the back end also steps through them as its sequencer state
  localparam logic [KIND_W-1:0] KIND_HEADER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ID_HI  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ID_LO  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CRC_LO = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CRC_HI = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 8'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] COUNT_RESET  = 8'h0A;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            first;  // opens a frame: header and count go first
    logic            last;   // closes a frame: CRC bytes follow
  } entry_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crc16_modbus_packet_framer.sv =====
// CRC-16/Modbus packet framer. Each channel ID taken on the slave stream becomes two
// bytes on the master stream (ID high, then low), one byte per cycle while the master
// side does not stall; the first ID of a frame is preceded by the header and count
// bytes and the NUM_CHANNELS-th ID is followed by the CRC low and high bytes, the high
// one marked tlast. The byte sequencer emits one byte per cycle while m_tready does
// not hold it, and a two-entry queue in front of it keeps the slave side taking IDs
// while bytes drain.
// CRC (init FFFF, reflected poly A001) covers header, count and all ID bytes.
// The user writes header and count registers through the cfg port only while idle; the block does not enforce it.
module crc16_modbus_packet_framer import ckf_pkg::*; #(
  parameter int NUM_CHANNELS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ID_W-1:0]      s_tdata,   // [15:0] channel_id
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
  output logic [KIND_W-1:0]    m_tuser,   // [2:0] byte_kind
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] count_byte;
  logic              push;
  logic              push_ready;
  entry_t            push_entry;
  logic              pop;
  logic              pop_valid;
  entry_t            pop_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      count_byte  <= COUNT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HEADER) begin
        header_byte <= cfg_data;
      end
      if (cfg_index == REG_COUNT) begin
        count_byte <= cfg_data;
      end
    end
  end

  ckf_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  ckf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid)
  );

  ckf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .header_byte (header_byte),
    .count_byte  (count_byte),
    .pop_entry   (pop_entry),
    .pop_valid   (pop_valid),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

// ===== rtl/core/ckf_front.sv =====
// Front end of the framer: accepts channel IDs and tags each with its frame position.
// Depends on ckf_pkg.
module ckf_front import ckf_pkg::*; #(
  parameter int NUM_CHANNELS = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [ID_W-1:0] s_tdata,   // [15:0] channel_id
  output logic            push,
  output entry_t          push_entry,
  input  logic            push_ready
);

  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             at_last;

  assign s_tready = push_ready;
  assign push     = s_tvalid && push_ready;
  assign at_last  = (cnt == CNT_W'(NUM_CHANNELS - 1));

  assign push_entry.id    = s_tdata;
  assign push_entry.first = (cnt == '0);
  assign push_entry.last  = at_last;

  always_comb begin
    cnt_next = cnt;
    if (push) begin
      cnt_next = at_last ? '0 : cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(NUM_CHANNELS))
    else $error("channel counter beyond frame length");

endmodule

// ===== rtl/core/ckf_queue.sv =====
// Two-entry queue between the front end and the byte sequencer.
// Depends on ckf_pkg.
module ckf_queue import ckf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   push_ready,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   pop_valid
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      fill <= fill + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !push_ready) && !(pop && !pop_valid))
    else $error("queue pushed when full or popped when empty");

endmodule

// ===== rtl/core/ckf_back.sv =====
// Back end of the framer: steps through the bytes of each queued ID, runs the CRC
// and holds the output register. Depends on ckf_pkg.
module ckf_back import ckf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] header_byte,
  input  logic [BYTE_W-1:0] count_byte,
  input  entry_t            pop_entry,
  input  logic              pop_valid,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,  // [7:0] out_byte
  output logic [KIND_W-1:0] m_tuser,  // [2:0] byte_kind
  output logic              m_tlast   // last_byte
);

  logic              busy;
  logic [KIND_W-1:0] phase;
  logic [KIND_W-1:0] phase_next;
  entry_t            cur;
  logic [CRC_W-1:0]  crc;
  logic [CRC_W-1:0]  crc_next;
  logic [BYTE_W-1:0] byte_sel;
  logic              load_ok;
  logic              advance;
  logic              done;

  assign load_ok = !m_tvalid || m_tready;
  assign advance = busy && load_ok;
  assign pop     = pop_valid && (!busy || done);

  always_comb begin
    byte_sel   = cur.id[BYTE_W-1:0];
    phase_next = phase;
    done       = 1'b0;
    crc_next   = crc;
    unique case (phase)
      KIND_HEADER: begin
        byte_sel   = header_byte;
        phase_next = KIND_COUNT;
        crc_next   = crc_feed(CRC_INIT, header_byte);
      end
      KIND_COUNT: begin
        byte_sel   = count_byte;
        phase_next = KIND_ID_HI;
        crc_next   = crc_feed(crc, count_byte);
      end
      KIND_ID_HI: begin
        byte_sel   = cur.id[ID_W-1:BYTE_W];
        phase_next = KIND_ID_LO;
        crc_next   = crc_feed(crc, cur.id[ID_W-1:BYTE_W]);
      end
      KIND_ID_LO: begin
        byte_sel   = cur.id[BYTE_W-1:0];
        phase_next = KIND_CRC_LO;
        done       = advance && !cur.last;
        crc_next   = crc_feed(crc, cur.id[BYTE_W-1:0]);
      end
      KIND_CRC_LO: begin
        byte_sel   = crc[BYTE_W-1:0];
        phase_next = KIND_CRC_HI;
      end
      KIND_CRC_HI: begin
        byte_sel   = crc[CRC_W-1:BYTE_W];
        done       = advance;
        crc_next   = CRC_INIT;
      end
      default: begin
        done = advance;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= KIND_HEADER;
      crc   <= CRC_INIT;
    end else begin
      if (advance) begin
        crc   <= crc_next;
        phase <= phase_next;
      end
      if (pop) begin
        busy  <= 1'b1;
        phase <= pop_entry.first ? KIND_HEADER : KIND_ID_HI;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_ok) begin
      m_tvalid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= byte_sel;
      m_tuser <= phase;
      m_tlast <= (phase == KIND_CRC_HI);
    end
  end

  a_last_on_crc_hi: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_CRC_HI)))
    else $error("last marker not on the CRC high byte");

  a_done_at_end: assert property (@(posedge clk) disable iff (rst)
    done |-> (phase == KIND_ID_LO || phase == KIND_CRC_HI))
    else $error("item finished before its final byte");

  a_count_after_header: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == KIND_HEADER) |=> (busy && phase == KIND_COUNT))
    else $error("count byte does not follow header");

endmodule

// ===== tb/tb_crc16_modbus_packet_framer.sv =====
// Self-checking testbench for crc16_modbus_packet_framer: drives channel IDs and register
// writes, predicts every frame byte including the CRC-16/Modbus, checks the byte stream.
// Depends on ckf_pkg and the framer RTL.
module tb_crc16_modbus_packet_framer import ckf_pkg::*; #(
  parameter int NUM_CHANNELS = 10
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT     = 18;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MAX = '1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              last;
  } frame_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ID_W-1:0]      s_tdata = '0;    // [15:0] channel_id
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;         // [7:0] out_byte
  logic [KIND_W-1:0]    m_tuser;         // [2:0] byte_kind
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  crc16_modbus_packet_framer #(.NUM_CHANNELS(NUM_CHANNELS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Framer model state
  logic [BYTE_W-1:0] header_reg = HEADER_RESET;
  logic [BYTE_W-1:0] count_reg  = COUNT_RESET;
  logic [CRC_W-1:0]  frame_crc  = CRC_INIT;
  logic [6:0]        ids_in_frame = '0;
  frame_byte_t       expected_bytes[$];

  int  mismatch_count = 0;
  int  bytes_checked  = 0;
  int  cycle_count    = 0;
  bit  src_idle_on    = 1'b1;
  bit  sink_idle_on   = 1'b1;
  bit  sink_hold_req  = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Feed one byte through the frame CRC (reflected, LSB first) and queue it
  function automatic void push_data(input logic [BYTE_W-1:0] b, input logic [KIND_W-1:0] k);
    logic lsb;
    frame_crc = frame_crc ^ {8'h00, b};
    repeat (8) begin
      lsb = frame_crc[0];
      frame_crc = {1'b0, frame_crc[CRC_W-1:1]};
      if (lsb) frame_crc = frame_crc ^ CRC_POLY;
    end
    expected_bytes.push_back('{b, k, 1'b0});
  endfunction

  function automatic void predict_frame_bytes(input logic [ID_W-1:0] id);
    if (ids_in_frame == 0) begin
      frame_crc = CRC_INIT;
      push_data(header_reg, KIND_HEADER);
      push_data(count_reg, KIND_COUNT);
    end
    push_data(id[15:8], KIND_ID_HI);
    push_data(id[7:0], KIND_ID_LO);
    ids_in_frame = ids_in_frame + 7'd1;
    if (ids_in_frame >= NUM_CHANNELS) begin
      expected_bytes.push_back('{frame_crc[7:0], KIND_CRC_LO, 1'b0});
      expected_bytes.push_back('{frame_crc[15:8], KIND_CRC_HI, 1'b1});
      frame_crc = CRC_INIT;
      ids_in_frame = '0;
    end
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return ID_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH %s", msg);
  endfunction

  // Offer one ID; valid stays high after the transfer so back-to-back IDs need no re-raise
  task automatic send_id(input logic [ID_W-1:0] id);
    if (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    do @(posedge clk); while (!s_tready);
    predict_frame_bytes(id);
  endtask

  // Drop valid and hold until every predicted byte has been seen
  task automatic drain_bytes();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HEADER: header_reg = val;
      REG_COUNT:  count_reg  = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else begin
        m_tready <= !sink_idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Sample the transfer at the edge, compare after the sender has made its prediction
  initial begin : byte_checker
    frame_byte_t got;
    frame_byte_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = '{m_tdata, m_tuser, m_tlast};
        @(negedge clk);
        if (expected_bytes.size() == 0) begin
          log_mismatch($sformatf("unexpected byte: data %02h kind %0d last %0d",
                                 got.data, got.kind, got.last));
        end else begin
          want = expected_bytes.pop_front();
          if (got.data !== want.data || got.kind !== want.kind || got.last !== want.last)
            log_mismatch($sformatf({"byte %0d: expected data %02h kind %0d last %0d, ",
                                    "got data %02h kind %0d last %0d"},
                                   bytes_checked, want.data, want.kind, want.last,
                                   got.data, got.kind, got.last));
        end
        bytes_checked++;
      end
    end
  end

  // Field extremes and walking patterns, running across a frame boundary
  task automatic test_id_extremes();
    logic [ID_W-1:0] ids[$];
    ids = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h8000, 16'h0001,
            16'hAAAA, 16'h5555, 16'h7FFF, 16'hFFFE, 16'h1234, 16'hFEDC};
    foreach (ids[i]) send_id(ids[i]);
  endtask

  // Extreme register values, writes in mid-frame, and writes to unused indexes
  task automatic test_register_settings();
    drain_bytes();
    write_reg(REG_HEADER, 8'h00);
    write_reg(REG_COUNT, 8'hFF);
    repeat (NUM_CHANNELS) send_id(rand_id());
    drain_bytes();
    write_reg(REG_COUNT + CFG_IDX_W'(1), 8'h5A);
    write_reg(REG_INDEX_MAX, 8'hA5);
    write_reg(REG_HEADER, 8'hFF);
    write_reg(REG_COUNT, 8'h00);
    repeat (NUM_CHANNELS) send_id(rand_id());
  endtask

  // Hold the receiver off while IDs keep coming, so the input side must stall
  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    sink_hold_req = 1'b1;
    repeat (20) send_id(rand_id());
    src_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (7) send_id(rand_id());
    drain_bytes();
    repeat (7) send_id(rand_id());
  endtask

  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (60) send_id(rand_id());
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Random frames, with new register settings between phases
  task automatic test_random_frames();
    repeat (5) begin
      drain_bytes();
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), BYTE_W'($urandom_range(255)));
      write_reg(REG_HEADER, BYTE_W'($urandom_range(255)));
      write_reg(REG_COUNT, BYTE_W'($urandom_range(255)));
      repeat (32) send_id(rand_id());
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_id_extremes();
    test_register_settings();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();
    test_random_frames();
    drain_bytes();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
